// ----- rtl/core/fsht_pkg.sv -----
// Shared types and constants for the floppy stepper head tracker.
package fsht_pkg;

    localparam int MAGNETS = 4;
    localparam int MAG_W = $clog2(MAGNETS);
    localparam int POS_W = 7;
    localparam int TRACK_W = 7;
    localparam int PHASE_W = 3;
    localparam logic [POS_W-1:0] MAX_POS_RESET = 7'd68;

    typedef struct packed {
        logic [MAGNETS-1:0] magnet_now;
        logic [MAGNETS-1:0] magnet_prev;
        logic [MAGNETS-1:0] magnet_prev2;
        logic [MAG_W-1:0]   last_magnet;
        logic [MAG_W-1:0]   last_magnet2;
        logic [POS_W-1:0]   head_position;
        logic [TRACK_W-1:0] held_track;
    } fsht_state_t;

    typedef struct packed {
        logic [TRACK_W-1:0] current_track;
        logic               track_changed;
        logic [TRACK_W-1:0] left_track;
    } fsht_result_t;

endpackage

// ----- rtl/core/fsht_step.sv -----
// Next-state and result logic for one stepper phase request.
module fsht_step import fsht_pkg::*; (
    input  logic [PHASE_W-1:0] phase,
    input  logic [POS_W-1:0]   max_head_position,
    input  fsht_state_t        state_cur,
    output fsht_state_t        state_nxt,
    output fsht_result_t       result
);

    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   mag_up;
    logic [MAG_W-1:0]   mag_dn;
    logic [POS_W:0]     pos_inc;
    logic [POS_W:0]     track_sum;
    logic [TRACK_W-1:0] cur_track;

    assign mag    = phase[PHASE_W-1:1];
    assign mag_up = mag + MAG_W'(1);
    assign mag_dn = mag - MAG_W'(1);

    always_comb begin
        state_nxt = state_cur;
        pos_inc   = '0;

        // history shuffle: older slot first, it reads the old prev bit
        state_nxt.magnet_prev2[state_cur.last_magnet2] =
            state_cur.magnet_prev[state_cur.last_magnet2];
        state_nxt.last_magnet2 = state_cur.last_magnet;
        state_nxt.magnet_prev[state_cur.last_magnet] =
            state_cur.magnet_now[state_cur.last_magnet];
        state_nxt.last_magnet = mag;

        if (!phase[0]) begin
            state_nxt.magnet_now[mag] = 1'b0;
        end else begin
            // step down before step up
            if (state_nxt.magnet_prev2[mag_up] && (state_nxt.head_position != '0)) begin
                state_nxt.head_position = state_nxt.head_position - POS_W'(1);
            end
            if (state_nxt.magnet_prev2[mag_dn]) begin
                pos_inc = {1'b0, state_nxt.head_position} + (POS_W+1)'(1);
                if (pos_inc > {1'b0, max_head_position}) begin
                    state_nxt.head_position = max_head_position;
                end else begin
                    state_nxt.head_position = pos_inc[POS_W-1:0];
                end
            end
            state_nxt.magnet_now[mag] = 1'b1;
        end

        track_sum = {1'b0, state_nxt.head_position} + (POS_W+1)'(1);
        cur_track = TRACK_W'(track_sum[POS_W:1]);
        state_nxt.held_track = cur_track;
    end

    assign result.current_track = cur_track;
    assign result.track_changed = (cur_track != state_cur.held_track);
    assign result.left_track    = state_cur.held_track;

endmodule

// ----- rtl/core/floppy_stepper_head_tracker.sv -----
// Top level of the floppy stepper head tracker: state, config and result registers.
//
//   channel  | ports                                         | dir
//   ---------+-----------------------------------------------+-----
//   input    | s_valid s_ready s_phase                       | in
//   result   | m_valid m_ready m_current_track               | out
//            | m_track_changed m_left_track                  |
//   config   | cfg_valid cfg_ready cfg_data                  | in
//
// One request per cycle while s_ready is high; its result appears in the
// output register in the cycle after acceptance. The state update is a
// single combinational pass. s_ready drops only while a result waits and
// m_ready is low. aresetn (synchronous) clears magnets, history, head position
// and track, and sets max_head_position to 68. Config is always ready.
module floppy_stepper_head_tracker import fsht_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PHASE_W-1:0] s_phase,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [TRACK_W-1:0] m_current_track,
    output logic               m_track_changed,
    output logic [TRACK_W-1:0] m_left_track,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [POS_W-1:0]   cfg_data
);

    fsht_state_t        state_reg;
    fsht_state_t        state_next;
    fsht_result_t       result_reg;
    fsht_result_t       result_next;
    logic [POS_W-1:0]   max_pos_reg;
    logic               m_valid_reg;
    logic               accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    fsht_step u_step (
        .phase             (s_phase),
        .max_head_position (max_pos_reg),
        .state_cur         (state_reg),
        .state_nxt         (state_next),
        .result            (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            max_pos_reg <= MAX_POS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_pos_reg <= cfg_data;
            end
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_current_track = result_reg.current_track;
    assign m_track_changed = result_reg.track_changed;
    assign m_left_track    = result_reg.left_track;

`ifndef SYNTHESIS
    a_changed_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_track_changed == (m_current_track != m_left_track)))
        else $error("track_changed disagrees with tracks");

    a_held_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg.held_track == m_current_track))
        else $error("held track differs from last result");

    a_accept_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request gave no result");

    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !accept) |=> $stable(state_reg))
        else $error("state changed without a request");
`endif

endmodule
